FILE: design/tft_pkg.sv
`timescale 1ns / 1ps

package tft_pkg;

  localparam int NIC_COUNT     = 4;
  localparam int NIC_SLOTS     = 4;
  localparam int PORTS_PER_NIC = 65536;
  localparam int PID_COUNT     = 32768;

  localparam int NIC_W   = $clog2(NIC_SLOTS);
  localparam int PORT_W  = $clog2(PORTS_PER_NIC);
  localparam int PORT_DEPTH = NIC_COUNT * PORTS_PER_NIC;
  localparam int PORT_AW = $clog2(PORT_DEPTH);
  localparam int PID_AW  = $clog2(PID_COUNT);
  localparam int PID_W   = 15;
  localparam int TAG_W   = 8;
  localparam int TIDX_W  = 18;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int IN_DATA_W  = 216;
  localparam int OUT_DATA_W = 32;

  // opcodes
  localparam logic [1:0] OP_PKT     = 2'd0;
  localparam logic [1:0] OP_PORT_WR = 2'd1;
  localparam logic [1:0] OP_TAG_WR  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_NIC_ADDR0  = 3'd0;
  localparam logic [2:0] REG_NIC_ADDR1  = 3'd1;
  localparam logic [2:0] REG_NIC_ADDR2  = 3'd2;
  localparam logic [2:0] REG_NIC_ADDR3  = 3'd3;
  localparam logic [2:0] REG_NIC_IN_USE = 3'd4;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [3:0] IHL_PLAIN = 4'd5;

  typedef struct packed {
    logic [14:0] table_value;
    logic [17:0] table_index;
    logic [15:0] src_port;
    logic [31:0] hdr_word4;
    logic [31:0] hdr_word3;
    logic [31:0] hdr_word2;
    logic [31:0] hdr_word1;
    logic [31:0] hdr_word0;
    logic [1:0]  opcode;
  } item_t;

  typedef struct packed {
    logic        write_done;
    logic        options_present;
    logic [15:0] checksum_out;
    logic [7:0]  tos_out;
    logic        tagged_res;
  } res_t;

  typedef struct packed {
    logic [NIC_SLOTS-1:0][31:0] nic_addr;
    logic [2:0]                 active;
  } cfg_t;

  typedef struct packed {
    logic               busy;
    logic [PORT_AW-1:0] addr;
  } clr_t;

  typedef struct packed {
    logic v1;
    logic v2;
  } occ_t;

endpackage

FILE: design/tcp_flow_tos_tagger_core.sv
`timescale 1ns / 1ps
// Channel | Dir | Ports                        | Beat contents
// in      | in  | in_tvalid/in_tready/in_tdata | one packet header or one table write
// out     | out | out_tvalid/out_tready/out_tdata | one result per input beat
// cfg     | in  | cfg_we/cfg_addr/cfg_wdata    | interface address and in-use registers
//
// Throughput is one beat per cycle while in_tready is high; a beat passes the
// port table read, tag table read and checksum fold before the result queue.
// After reset a sweep of all 262144 port-table entries, one per cycle, zeroes
// both tables; in_tready stays low until it ends, cfg writes are taken.
// in_tready is credit based: it drops when the four-entry result queue plus the
// beats in flight would fill it, so out_tready stalls never lose a result.

module tcp_flow_tos_tagger_core (
  input  logic         clk,
  input  logic         rst_n,
  // opcode, hdr_word0..hdr_word4, src_port, table_index, table_value, zero pad
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [215:0] in_tdata,
  // tagged_res, tos_out, checksum_out, options_present, write_done, zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  // configuration
  logic [tft_pkg::NIC_SLOTS-1:0][31:0] nic_addr_r;
  logic [2:0]                          nic_in_use_r;
  tft_pkg::cfg_t                       cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nic_addr_r   <= '0;
      nic_in_use_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        tft_pkg::REG_NIC_ADDR0:  nic_addr_r[0] <= cfg_wdata;
        tft_pkg::REG_NIC_ADDR1:  nic_addr_r[1] <= cfg_wdata;
        tft_pkg::REG_NIC_ADDR2:  nic_addr_r[2] <= cfg_wdata;
        tft_pkg::REG_NIC_ADDR3:  nic_addr_r[3] <= cfg_wdata;
        tft_pkg::REG_NIC_IN_USE: nic_in_use_r  <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.nic_addr = nic_addr_r;
  assign cfg.active   = (nic_in_use_r > 3'(tft_pkg::NIC_COUNT)) ?
                        3'(tft_pkg::NIC_COUNT) : nic_in_use_r;

  // table clearing sweep
  logic                        clr_busy_r, clr_busy_nxt;
  logic [tft_pkg::PORT_AW-1:0] clr_addr_r, clr_addr_nxt;
  tft_pkg::clr_t               clr;

  assign clr_addr_nxt = clr_busy_r ? clr_addr_r + 1'b1 : clr_addr_r;
  assign clr_busy_nxt = clr_busy_r &&
                        (clr_addr_r != tft_pkg::PORT_AW'(tft_pkg::PORT_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign clr.busy = clr_busy_r;
  assign clr.addr = clr_addr_r;

  // datapath
  tft_pkg::item_t             item;
  tft_pkg::occ_t              occ;
  tft_pkg::res_t              pipe_res;
  tft_pkg::res_t              fifo_res;
  logic                       pipe_valid;
  logic                       acc;
  logic [tft_pkg::CNT_W-1:0]  fifo_cnt;
  logic [tft_pkg::CNT_W-1:0]  in_flight;

  assign item = in_tdata[$bits(tft_pkg::item_t)-1:0];

  assign in_flight = fifo_cnt + tft_pkg::CNT_W'(occ.v1) + tft_pkg::CNT_W'(occ.v2);
  assign in_tready = !clr_busy_r && (in_flight < tft_pkg::CNT_W'(tft_pkg::FIFO_DEPTH));
  assign acc       = in_tvalid && in_tready;

  tft_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .item      (item),
    .cfg       (cfg),
    .clr       (clr),
    .occ       (occ),
    .res_valid (pipe_valid),
    .res       (pipe_res)
  );

  tft_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (pipe_valid),
    .din        (pipe_res),
    .pop        (out_tready),
    .dout_valid (out_tvalid),
    .dout       (fifo_res),
    .count      (fifo_cnt)
  );

  assign out_tdata = {(tft_pkg::OUT_DATA_W - $bits(tft_pkg::res_t))'(0), fifo_res};

endmodule

FILE: design/tft_ram.sv
`timescale 1ns / 1ps

module tft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/tft_pipe.sv
`timescale 1ns / 1ps

module tft_pipe (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  tft_pkg::item_t  item,
  input  tft_pkg::cfg_t   cfg,
  input  tft_pkg::clr_t   clr,
  output tft_pkg::occ_t   occ,
  output logic            res_valid,
  output tft_pkg::res_t   res
);

  // ---------------- stage 0: match, port table access ----------------
  logic [tft_pkg::NIC_SLOTS-1:0] hit;
  logic [tft_pkg::NIC_W-1:0]     nic_sel;
  logic                          is_lookup0;
  logic                          opt0;
  logic                          port_nic_ok;
  logic                          port_we;
  logic [tft_pkg::PORT_AW-1:0]   port_waddr;
  logic [tft_pkg::PID_W-1:0]     port_wdata;
  logic [tft_pkg::PORT_AW-1:0]   port_raddr;
  logic [tft_pkg::PID_W-1:0]     pid_rdata;

  always_comb begin
    for (int i = 0; i < tft_pkg::NIC_SLOTS; i++) begin
      hit[i] = (3'(i) < cfg.active) && (cfg.nic_addr[i] == item.hdr_word3);
    end
    nic_sel = '0;
    for (int i = tft_pkg::NIC_SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        nic_sel = tft_pkg::NIC_W'(i);
      end
    end
  end

  assign opt0       = item.hdr_word0[27:24] > tft_pkg::IHL_PLAIN;
  assign is_lookup0 = (item.opcode == tft_pkg::OP_PKT) && !opt0 &&
                      (item.hdr_word2[23:16] == tft_pkg::PROTO_TCP) && (|hit);

  assign port_nic_ok = {1'b0, item.table_index[17:16]} < 3'(tft_pkg::NIC_COUNT);
  assign port_we     = clr.busy ||
                       (acc && (item.opcode == tft_pkg::OP_PORT_WR) && port_nic_ok);
  assign port_waddr  = clr.busy ? clr.addr : item.table_index[tft_pkg::PORT_AW-1:0];
  assign port_wdata  = clr.busy ? '0 : item.table_value;
  assign port_raddr  = {nic_sel, item.src_port};

  tft_ram #(
    .WIDTH (tft_pkg::PID_W),
    .DEPTH (tft_pkg::PORT_DEPTH)
  ) u_port_ram (
    .clk   (clk),
    .we    (port_we),
    .waddr (port_waddr),
    .wdata (port_wdata),
    .raddr (port_raddr),
    .rdata (pid_rdata)
  );

  // ---------------- stage 1: header sum, tag table access ----------------
  logic                        v1_r;
  logic [1:0]                  op1_r;
  logic                        lookup1_r;
  logic                        opt1_r;
  logic [7:0]                  tos1_r;
  logic [15:0]                 csum1_r;
  logic [7:0]                  vihl1_r;
  logic [15:0]                 tlen1_r;
  logic [31:0]                 w1_1_r;
  logic [15:0]                 w2h1_r;
  logic [31:0]                 w3_1_r;
  logic [31:0]                 w4_1_r;
  logic [tft_pkg::TIDX_W-1:0]  tidx1_r;
  logic [tft_pkg::TAG_W-1:0]   tval1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    op1_r     <= item.opcode;
    lookup1_r <= is_lookup0;
    opt1_r    <= opt0;
    tos1_r    <= item.hdr_word0[23:16];
    csum1_r   <= item.hdr_word2[15:0];
    vihl1_r   <= item.hdr_word0[31:24];
    tlen1_r   <= item.hdr_word0[15:0];
    w1_1_r    <= item.hdr_word1;
    w2h1_r    <= item.hdr_word2[31:16];
    w3_1_r    <= item.hdr_word3;
    w4_1_r    <= item.hdr_word4;
    tidx1_r   <= item.table_index;
    tval1_r   <= item.table_value[tft_pkg::TAG_W-1:0];
  end

  // sum of every header half-word except the tos/checksum parts
  logic [19:0]                 psum1;
  logic                        pid_ok1;
  logic                        tag_idx_ok;
  logic                        tag_we;
  logic [tft_pkg::PID_AW-1:0]  tag_waddr;
  logic [tft_pkg::TAG_W-1:0]   tag_wdata;
  logic [tft_pkg::TAG_W-1:0]   tag_rdata;

  assign psum1 = 20'({vihl1_r, 8'h00}) + 20'(tlen1_r) + 20'(w1_1_r[31:16]) +
                 20'(w1_1_r[15:0]) + 20'(w2h1_r) + 20'(w3_1_r[31:16]) +
                 20'(w3_1_r[15:0]) + 20'(w4_1_r[31:16]) + 20'(w4_1_r[15:0]);

  assign pid_ok1    = (pid_rdata != '0) &&
                      ({1'b0, pid_rdata} < 16'(tft_pkg::PID_COUNT));
  assign tag_idx_ok = tidx1_r < tft_pkg::TIDX_W'(tft_pkg::PID_COUNT);
  assign tag_we     = clr.busy || (v1_r && (op1_r == tft_pkg::OP_TAG_WR) && tag_idx_ok);
  assign tag_waddr  = clr.busy ? clr.addr[tft_pkg::PID_AW-1:0]
                               : tidx1_r[tft_pkg::PID_AW-1:0];
  assign tag_wdata  = clr.busy ? '0 : tval1_r;

  tft_ram #(
    .WIDTH (tft_pkg::TAG_W),
    .DEPTH (tft_pkg::PID_COUNT)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (pid_rdata[tft_pkg::PID_AW-1:0]),
    .rdata (tag_rdata)
  );

  // ---------------- stage 2: checksum and result ----------------
  logic        v2_r;
  logic [1:0]  op2_r;
  logic        lookup2_r;
  logic        opt2_r;
  logic [7:0]  tos2_r;
  logic [15:0] csum2_r;
  logic [19:0] psum2_r;
  logic        pid_ok2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    op2_r     <= op1_r;
    lookup2_r <= lookup1_r;
    opt2_r    <= opt1_r;
    tos2_r    <= tos1_r;
    csum2_r   <= csum1_r;
    psum2_r   <= psum1;
    pid_ok2_r <= pid_ok1;
  end

  logic [7:0]  tag2;
  logic [19:0] sum2;
  logic [16:0] fold_a;
  logic [16:0] fold_b;
  logic [15:0] new_csum;

  assign tag2     = pid_ok2_r ? tag_rdata : '0;
  assign sum2     = psum2_r + 20'(tag2);
  assign fold_a   = 17'(sum2[15:0]) + 17'(sum2[19:16]);
  assign fold_b   = 17'(fold_a[15:0]) + 17'(fold_a[16]);
  assign new_csum = ~fold_b[15:0];

  always_comb begin
    res = '0;
    case (op2_r)
      tft_pkg::OP_PKT: begin
        res.tagged_res      = lookup2_r;
        res.tos_out         = lookup2_r ? tag2 : tos2_r;
        res.checksum_out    = lookup2_r ? new_csum : csum2_r;
        res.options_present = opt2_r;
      end
      tft_pkg::OP_PORT_WR, tft_pkg::OP_TAG_WR: begin
        res.write_done = 1'b1;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  assign res_valid = v2_r;
  assign occ.v1    = v1_r;
  assign occ.v2    = v2_r;

endmodule

FILE: design/tft_out_fifo.sv
`timescale 1ns / 1ps

module tft_out_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  tft_pkg::res_t              din,
  input  logic                       pop,
  output logic                       dout_valid,
  output tft_pkg::res_t              dout,
  output logic [tft_pkg::CNT_W-1:0]  count
);

  tft_pkg::res_t                mem_r [tft_pkg::FIFO_DEPTH];
  logic [tft_pkg::FIFO_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [tft_pkg::FIFO_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [tft_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                         do_pop;

  assign do_pop     = pop && (cnt_r != '0);
  assign wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout_valid = cnt_r != '0;
  assign dout       = mem_r[rd_ptr_r];
  assign count      = cnt_r;

endmodule

FILE: design/tft_checker.sv
`timescale 1ns / 1ps

module tft_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata
);

  // table sweep starts right after reset
  a_sweep_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready right after reset");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_write_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[26]) |-> (out_tdata[25:0] == 26'd0))
    else $error("write result carries packet fields");

  a_tagged_plain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (!out_tdata[25] && !out_tdata[26]))
    else $error("tagged result flagged as options or write");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:27] == 5'd0))
    else $error("output pad bits not zero");

endmodule

bind tcp_flow_tos_tagger_core tft_checker u_tft_checker (.*);

FILE: sim/tft_tag_checker.sv
`timescale 1ns / 1ps

module tft_tag_checker
  import tft_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [215:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [31:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  output int           fail_count,
  output int           pending
);

  // shadow copies of the lookup tables and interface registers
  bit   [PID_W-1:0] pid_by_port [PORT_DEPTH];
  bit   [TAG_W-1:0] tag_by_pid  [PID_COUNT];
  logic [31:0]      nic_ip      [NIC_SLOTS];
  logic [2:0]       nics_on;
  res_t             tos_expect_q[$];

  function automatic logic [15:0] ipv4_csum(input logic [31:0] w0, input logic [31:0] w1,
                                            input logic [31:0] w2, input logic [31:0] w3,
                                            input logic [31:0] w4);
    logic [19:0] acc;
    // checksum field itself counts as zero
    acc = 20'(w0[31:16]) + 20'(w0[15:0]) + 20'(w1[31:16]) + 20'(w1[15:0])
        + 20'(w2[31:16]) + 20'(w3[31:16]) + 20'(w3[15:0])
        + 20'(w4[31:16]) + 20'(w4[15:0]);
    acc = 20'(acc[15:0]) + 20'(acc[19:16]);
    acc = 20'(acc[15:0]) + 20'(acc[19:16]);
    return ~acc[15:0];
  endfunction

  // applies table writes and returns the result a beat should produce
  function automatic res_t predict_tag(input item_t it);
    res_t             r;
    int               active;
    int               hit;
    int               i;
    logic [PID_W-1:0] pid;
    logic [TAG_W-1:0] tag;
    logic [31:0]      w0;
    r   = '0;
    hit = -1;
    case (it.opcode)
      OP_PORT_WR: begin
        if (int'(it.table_index[TIDX_W-1:PORT_W]) < NIC_COUNT)
          pid_by_port[it.table_index] = it.table_value;
        r.write_done = 1'b1;
      end
      OP_TAG_WR: begin
        if (it.table_index < PID_COUNT)
          tag_by_pid[it.table_index[PID_AW-1:0]] = it.table_value[TAG_W-1:0];
        r.write_done = 1'b1;
      end
      OP_PKT: begin
        r.tos_out      = it.hdr_word0[23:16];
        r.checksum_out = it.hdr_word2[15:0];
        if (it.hdr_word0[27:24] > IHL_PLAIN) begin
          r.options_present = 1'b1;
        end else if (it.hdr_word2[23:16] == PROTO_TCP) begin
          active = (int'(nics_on) > NIC_COUNT) ? NIC_COUNT : int'(nics_on);
          for (i = 0; i < NIC_SLOTS; i++)
            if (hit < 0 && i < active && nic_ip[i] == it.hdr_word3) hit = i;
          if (hit >= 0) begin
            pid = pid_by_port[hit * PORTS_PER_NIC + int'(it.src_port)];
            tag = (pid != 0 && int'(pid) < PID_COUNT) ? tag_by_pid[pid[PID_AW-1:0]] : '0;
            w0 = it.hdr_word0;
            w0[23:16] = tag;
            r.tagged_res   = 1'b1;
            r.tos_out      = tag;
            r.checksum_out = ipv4_csum(w0, it.hdr_word1, it.hdr_word2, it.hdr_word3,
                                       it.hdr_word4);
          end
        end
      end
      default: ;  // unused opcode: all-zero result
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      foreach (nic_ip[k]) nic_ip[k] = '0;
      nics_on = '0;
      tos_expect_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_NIC_ADDR0:  nic_ip[0] = cfg_wdata;
          REG_NIC_ADDR1:  nic_ip[1] = cfg_wdata;
          REG_NIC_ADDR2:  nic_ip[2] = cfg_wdata;
          REG_NIC_ADDR3:  nic_ip[3] = cfg_wdata;
          REG_NIC_IN_USE: nics_on   = cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        tos_expect_q.push_back(predict_tag(item_t'(in_tdata[$bits(item_t)-1:0])));
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[$bits(res_t)-1:0]);
        if (tos_expect_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, actual %h",
                   $time, got);
          fail_count++;
        end else begin
          want = tos_expect_q.pop_front();
          check_field("tagged_res",      16'(want.tagged_res),      16'(got.tagged_res));
          check_field("tos_out",         16'(want.tos_out),         16'(got.tos_out));
          check_field("checksum_out",    want.checksum_out,         got.checksum_out);
          check_field("options_present", 16'(want.options_present), 16'(got.options_present));
          check_field("write_done",      16'(want.write_done),      16'(got.write_done));
        end
      end
    end
    pending = tos_expect_q.size();
  end

endmodule

FILE: sim/tb_tcp_flow_tos_tagger_core.sv
`timescale 1ns / 1ps

module tb_tcp_flow_tos_tagger_core;
  import tft_pkg::*;

  // table clear after reset sweeps all 262144 port-table entries with nothing moving
  localparam int         QUIET_LIMIT = 1000000;
  localparam int         HOLD_CYCLES = 300;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [215:0] in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic         cfg_we     = 1'b0;
  logic [2:0]   cfg_addr   = '0;
  logic [31:0]  cfg_wdata  = '0;

  int fail_count;
  int pending;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  logic [31:0] nic_ip [NIC_SLOTS];
  logic [15:0] port_pool [8];
  logic [14:0] pid_pool [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tcp_flow_tos_tagger_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  tft_tag_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic item_t noise_item();
    item_t it;
    it.opcode      = 2'($urandom());
    it.hdr_word0   = $urandom();
    it.hdr_word1   = $urandom();
    it.hdr_word2   = $urandom();
    it.hdr_word3   = $urandom();
    it.hdr_word4   = $urandom();
    it.src_port    = 16'($urandom());
    it.table_index = 18'($urandom());
    it.table_value = 15'($urandom());
    return it;
  endfunction

  function automatic item_t pkt_item(input logic [31:0] src, input logic [15:0] port,
                                     input logic [3:0] ihl, input logic [7:0] proto);
    item_t it;
    it = noise_item();
    it.opcode            = OP_PKT;
    it.hdr_word0[27:24]  = ihl;
    it.hdr_word2[23:16]  = proto;
    it.hdr_word3         = src;
    it.src_port          = port;
    return it;
  endfunction

  function automatic item_t port_wr(input logic [1:0] nic, input logic [15:0] port,
                                    input logic [14:0] pid);
    item_t it;
    it = noise_item();
    it.opcode      = OP_PORT_WR;
    it.table_index = {nic, port};
    it.table_value = pid;
    return it;
  endfunction

  function automatic item_t tag_wr(input logic [17:0] pid, input logic [7:0] tag);
    item_t it;
    it = noise_item();
    it.opcode           = OP_TAG_WR;
    it.table_index      = pid;
    it.table_value[7:0] = tag;
    return it;
  endfunction

  function automatic item_t random_item();
    int          pick;
    logic [15:0] port;
    logic [14:0] pid;
    logic [31:0] src;
    item_t       it;
    pick = $urandom_range(99);
    port = ($urandom_range(99) < 85) ? port_pool[$urandom_range(7)] : 16'($urandom());
    pid  = ($urandom_range(99) < 80) ? pid_pool[$urandom_range(7)] : 15'($urandom());
    if (pick < 20) begin
      it = port_wr(2'($urandom()), port, pid);
    end else if (pick < 32) begin
      it = tag_wr(($urandom_range(99) < 85) ? 18'(pid) : 18'($urandom()), 8'($urandom()));
    end else if (pick < 95) begin
      src = ($urandom_range(99) < 80) ? nic_ip[$urandom_range(NIC_SLOTS - 1)] : $urandom();
      it = pkt_item(src, port,
                    ($urandom_range(99) < 85) ? IHL_PLAIN : 4'($urandom()),
                    ($urandom_range(99) < 90) ? PROTO_TCP : 8'($urandom()));
    end else begin
      it = noise_item();
      it.opcode = OP_UNUSED;
    end
    return it;
  endfunction

  // called and returns at a falling edge; valid stays up between back-to-back beats
  task automatic send_beat(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {5'b0, it};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
  endtask

  task automatic program_nics(input logic [31:0] a0, input logic [31:0] a1,
                              input logic [31:0] a2, input logic [31:0] a3,
                              input logic [2:0] used);
    nic_ip[0] = a0;
    nic_ip[1] = a1;
    nic_ip[2] = a2;
    nic_ip[3] = a3;
    write_reg(REG_NIC_ADDR0, a0);
    write_reg(REG_NIC_ADDR1, a1);
    write_reg(REG_NIC_ADDR2, a2);
    write_reg(REG_NIC_ADDR3, a3);
    write_reg(REG_NIC_IN_USE, 32'(used) | ($urandom() & 32'hFFFF_FFF8));
    cfg_we = 1'b0;
  endtask

  initial begin
    logic [31:0] ip_a;
    logic [31:0] ip_b;
    logic [31:0] a0;
    logic [31:0] a1;
    logic [31:0] a2;
    logic [31:0] a3;
    logic [2:0]  in_use_seq [8];
    item_t       it;

    ip_a = 32'hC0A8_0001;
    ip_b = 32'h0A00_0002;
    in_use_seq = '{3'd4, 3'd2, 3'd7, 3'd4, 3'd3, 3'd1, 3'd6, 3'd4};
    port_pool[0] = 16'h0000;
    port_pool[7] = 16'hFFFF;
    pid_pool[0]  = 15'd0;
    pid_pool[7]  = 15'h7FFF;
    for (int k = 1; k < 7; k++) begin
      port_pool[k] = 16'($urandom());
      pid_pool[k]  = 15'($urandom_range(32767, 1));
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // interface 2 repeats interface 1 so first match must win
    program_nics(ip_a, ip_b, ip_b, 32'hFFFF_FFFF, 3'd4);
    // indexes past the register list must be dropped
    write_reg(REG_NIC_IN_USE + 3'd1, $urandom());
    write_reg(REG_NIC_IN_USE + 3'd2, $urandom());
    write_reg(REG_NIC_IN_USE + 3'd3, $urandom());
    cfg_we = 1'b0;

    send_beat(port_wr(2'd0, 16'd80, 15'd5));
    send_beat(tag_wr(18'd5, 8'hAB));
    send_beat(port_wr(2'd1, 16'hFFFF, 15'h7FFF));
    send_beat(tag_wr(18'h07FFF, 8'hFF));
    send_beat(tag_wr(18'd0, 8'h55));
    send_beat(tag_wr(18'h3FFFF, 8'h66));  // pid out of range, dropped
    send_beat(tag_wr(18'h08000, 8'h77));  // first pid past the table
    send_beat(port_wr(2'd3, 16'hFFFF, 15'd9));
    send_beat(tag_wr(18'd9, 8'h3C));
    send_beat(port_wr(2'd2, 16'd443, 15'd5));
    send_beat(pkt_item(ip_a, 16'd80, IHL_PLAIN, PROTO_TCP));
    send_beat(pkt_item(ip_b, 16'hFFFF, IHL_PLAIN, PROTO_TCP));
    send_beat(pkt_item(ip_a, 16'd81, IHL_PLAIN, PROTO_TCP));       // pid 0 gives tag 0
    send_beat(pkt_item(32'hFFFF_FFFF, 16'hFFFF, IHL_PLAIN, PROTO_TCP));
    send_beat(pkt_item(ip_b, 16'd443, IHL_PLAIN, PROTO_TCP));      // hits interface 1
    send_beat(pkt_item(ip_a, 16'd80, IHL_PLAIN, 8'd17));
    send_beat(pkt_item(ip_a, 16'd80, 4'd6, PROTO_TCP));
    send_beat(pkt_item(ip_a, 16'd80, 4'hF, PROTO_TCP));
    send_beat(pkt_item(ip_a, 16'd80, 4'd0, PROTO_TCP));            // short ihl still tagged
    send_beat(pkt_item(32'h0102_0304, 16'd80, IHL_PLAIN, PROTO_TCP));
    it = noise_item();
    it.opcode = OP_UNUSED;
    send_beat(it);
    send_beat('0);
    it = '1;
    it.opcode = OP_PKT;
    send_beat(it);

    settle();
    program_nics(ip_a, ip_b, ip_b, 32'hFFFF_FFFF, 3'd0);
    send_beat(pkt_item(ip_a, 16'd80, IHL_PLAIN, PROTO_TCP));
    settle();
    program_nics(ip_a, ip_b, ip_b, 32'hFFFF_FFFF, 3'd7);       // saturates to all four
    send_beat(pkt_item(32'hFFFF_FFFF, 16'hFFFF, IHL_PLAIN, PROTO_TCP));

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      if (ph == 3) begin
        a0 = 32'h0000_0000;
        a1 = 32'hFFFF_FFFF;
        a2 = 32'h0000_0000;
        a3 = $urandom();
      end else begin
        a0 = $urandom();
        a1 = $urandom();
        a2 = ($urandom_range(3) == 0) ? a0 : $urandom();
        a3 = $urandom();
      end
      program_nics(a0, a1, a2, a3, in_use_seq[ph]);
      send_idle_pct  = (ph % 4 == 1) ? 60 : ((ph % 4 == 3) ? 36 : 0);
      recv_stall_pct = (ph % 4 == 2) ? 60 : ((ph % 4 == 3) ? 36 : 0);
      for (int n = 0; n < 100; n++) begin
        if (ph == 4 && n == 10) hold_req = 1'b1;  // fill the result queue
        if (ph == 5 && n == 50) settle();          // let it run dry mid-phase
        send_beat(random_item());
      end
    end

    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
